>>> src/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg: baseline cross correlator shared definitions
// sizes, register indexes, status codes, payload and controller types
// ----------------------------------------------------------------------------
`default_nettype none

package bcc_pkg;

  // store geometry
  localparam int ANT_MAX     = 16;
  localparam int POL_MAX     = 2;
  localparam int STEP_MAX    = 64;
  localparam int CHAN_MAX    = 16;
  localparam int SAMPLE_BITS = 8;

  localparam int ANT_BITS   = $clog2(ANT_MAX);
  localparam int POL_BITS   = $clog2(POL_MAX);
  localparam int STEP_BITS  = $clog2(STEP_MAX);
  localparam int CHAN_BITS  = $clog2(CHAN_MAX);
  localparam int ADDR_BITS  = CHAN_BITS + ANT_BITS + POL_BITS + STEP_BITS;
  localparam int STORE_DEPTH = CHAN_MAX * ANT_MAX * POL_MAX * STEP_MAX;

  // register widths
  localparam int ANT_CNT_BITS  = 5;
  localparam int POL_CNT_BITS  = 2;
  localparam int STEP_CNT_BITS = 7;
  localparam int CHAN_CNT_BITS = 5;
  localparam int GRP_BITS      = 5;
  localparam int NORM_BITS     = 32;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;

  // payload widths
  localparam int BL_BITS   = 8;
  localparam int VIS_BITS  = 36;
  localparam int FRAC_BITS = 24;

  // datapath widths
  localparam int PROD_BITS  = 2 * SAMPLE_BITS + 1;
  localparam int ACC_BITS   = PROD_BITS + $clog2(STEP_MAX * CHAN_MAX) + 1;
  localparam int SCALE_BITS = ACC_BITS + NORM_BITS;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ANTENNA_COUNT = 3'd0,
    REG_POL_COUNT     = 3'd1,
    REG_STEP_COUNT    = 3'd2,
    REG_CHANNEL_COUNT = 3'd3,
    REG_AVG_GROUP     = 3'd4,
    REG_NORM_RECIP    = 3'd5
  } reg_index_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_AVG   = 2'd2
  } status_t;

  typedef enum logic {
    FUNC_LOAD      = 1'b0,
    FUNC_CORRELATE = 1'b1
  } func_t;

  typedef struct packed {
    func_t                         func;
    logic [3:0]                    chan_index;
    logic [3:0]                    ant_index;
    logic                          pol_index;
    logic [5:0]                    step_index;
    logic signed [SAMPLE_BITS-1:0] sample_re;
    logic signed [SAMPLE_BITS-1:0] sample_im;
    logic [BL_BITS-1:0]            baseline_index;
    logic                          pol_first;
    logic                          pol_second;
    logic [3:0]                    out_chan;
  } req_t;

  typedef struct packed {
    logic signed [VIS_BITS-1:0] vis_re;
    logic signed [VIS_BITS-1:0] vis_im;
    logic [3:0]                 ant_first;
    logic [3:0]                 ant_second;
    status_t                    status;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_READ,
    ST_DRAIN,
    ST_MAG,
    ST_MUL,
    ST_SAT
  } state_t;

  typedef struct packed {
    logic write;
    logic latch;
    logic read;
    logic mag;
    logic mul;
    logic load_result;
  } ctrl_cmd_t;

  typedef struct packed {
    logic err;
    logic zero_steps;
    logic last_read;
    logic pipe_empty;
  } ctrl_stat_t;

endpackage

`default_nettype wire

>>> src/baseline_cross_correlator_unit.sv
// ----------------------------------------------------------------------------
// baseline_cross_correlator_unit: X engine for one baseline visibility
// a load transaction writes one sample to the store; a correlate transaction
// reads N store pairs and then gives done, where N = steps * averaged
// channels (one store read pair per cycle); the reads are skipped when the
// step count is zero, and an error status gives done from evaluation;
// busy stays high until the cycle done is shown, when the next transaction
// can be taken; results cannot be stalled; done is a one-cycle strobe
// synchronous reset restores the register defaults and idles the controller;
// the sample store is not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module baseline_cross_correlator_unit (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_write,
  input  logic [bcc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [bcc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  // command side: transaction taken when start is high and busy is low
  input  logic                               start,
  output logic                               busy,
  input  bcc_pkg::req_t                      req,
  // result side: one transaction per correlate request, marked by done
  output logic                               done,
  output bcc_pkg::result_t                   result
);
  import bcc_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  // controller: idle, evaluate, read loop, drain, magnitude, scale, saturate
  bcc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (req.func),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // datapath: registers, store, mac pipe and output register
  bcc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result)
  );

endmodule

`default_nettype wire

>>> src/bcc_ctrl.sv
// ----------------------------------------------------------------------------
// bcc_ctrl: baseline cross correlator controller
// sequences evaluation, the read loop, drain, scaling and result strobe
// ----------------------------------------------------------------------------
`default_nettype none

module bcc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  bcc_pkg::func_t      func,
  input  bcc_pkg::ctrl_stat_t stat,
  output bcc_pkg::ctrl_cmd_t  cmd,
  output logic                busy,
  output logic                done
);
  import bcc_pkg::*;

  state_t state, state_next;
  logic   done_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (func == FUNC_CORRELATE) begin
            cmd.latch  = 1'b1;
            state_next = ST_EVAL;
          end else begin
            cmd.write = 1'b1;
          end
        end
      end
      ST_EVAL: begin
        if (stat.err) begin
          cmd.load_result = 1'b1;
          done_next       = 1'b1;
          state_next      = ST_IDLE;
        end else if (stat.zero_steps) begin
          state_next = ST_MAG;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read = 1'b1;
        if (stat.last_read) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (stat.pipe_empty) begin
          state_next = ST_MAG;
        end
      end
      ST_MAG: begin
        cmd.mag    = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_SAT;
      end
      ST_SAT: begin
        cmd.load_result = 1'b1;
        done_next       = 1'b1;
        state_next      = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

`default_nettype wire

>>> src/bcc_datapath.sv
// ----------------------------------------------------------------------------
// bcc_datapath: baseline cross correlator datapath
// config registers, sample store, multiply-accumulate pipe, scale and saturate
// ----------------------------------------------------------------------------
`default_nettype none

module bcc_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [bcc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [bcc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  bcc_pkg::req_t                        req,
  input  bcc_pkg::ctrl_cmd_t                   cmd,
  output bcc_pkg::ctrl_stat_t                  stat,
  output bcc_pkg::result_t                     result
);
  import bcc_pkg::*;

  // antenna a1 = largest a with a(a+1)/2 <= b, counted by independent compares
  function automatic logic [ANT_BITS-1:0] tri_root(input logic [BL_BITS-1:0] b);
    int cnt;
    cnt = 0;
    for (int k = 1; k < ANT_MAX; k++) begin
      if (int'(b) >= ((k * (k + 1)) >> 1)) begin
        cnt = cnt + 1;
      end
    end
    return ANT_BITS'(cnt);
  endfunction

  // configuration registers
  logic [ANT_CNT_BITS-1:0]  antenna_count;
  logic [POL_CNT_BITS-1:0]  pol_count;
  logic [STEP_CNT_BITS-1:0] step_count;
  logic [CHAN_CNT_BITS-1:0] channel_count;
  logic [GRP_BITS-1:0]      avg_group;
  logic [NORM_BITS-1:0]     norm_recip;

  always_ff @(posedge clk) begin
    if (rst) begin
      antenna_count <= ANT_CNT_BITS'(16);
      pol_count     <= POL_CNT_BITS'(2);
      step_count    <= STEP_CNT_BITS'(64);
      channel_count <= CHAN_CNT_BITS'(16);
      avg_group     <= GRP_BITS'(1);
      norm_recip    <= NORM_BITS'(32'd16777216);
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_ANTENNA_COUNT: antenna_count <= cfg_data[ANT_CNT_BITS-1:0];
        REG_POL_COUNT:     pol_count     <= cfg_data[POL_CNT_BITS-1:0];
        REG_STEP_COUNT:    step_count    <= cfg_data[STEP_CNT_BITS-1:0];
        REG_CHANNEL_COUNT: channel_count <= cfg_data[CHAN_CNT_BITS-1:0];
        REG_AVG_GROUP:     avg_group     <= cfg_data[GRP_BITS-1:0];
        REG_NORM_RECIP:    norm_recip    <= cfg_data[NORM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // effective counts
  logic [ANT_CNT_BITS-1:0]  n_ant;
  logic [POL_CNT_BITS-1:0]  n_pol;
  logic [STEP_CNT_BITS-1:0] n_step;
  logic [CHAN_CNT_BITS-1:0] n_chan;

  assign n_ant  = (antenna_count > ANT_CNT_BITS'(ANT_MAX)) ? ANT_CNT_BITS'(ANT_MAX)
                                                           : antenna_count;
  assign n_pol  = (pol_count > POL_CNT_BITS'(POL_MAX)) ? POL_CNT_BITS'(POL_MAX) : pol_count;
  assign n_step = (step_count > STEP_CNT_BITS'(STEP_MAX)) ? STEP_CNT_BITS'(STEP_MAX)
                                                          : step_count;
  assign n_chan = (channel_count > CHAN_CNT_BITS'(CHAN_MAX)) ? CHAN_CNT_BITS'(CHAN_MAX)
                                                             : channel_count;

  // request evaluation
  logic [2*ANT_CNT_BITS-1:0] n_bl_prod;
  logic [2*ANT_CNT_BITS-2:0] n_bl;
  logic [ANT_BITS-1:0]       a1_in;
  logic [BL_BITS:0]          tri_prod;
  logic [BL_BITS-1:0]        a2_diff;
  logic [2*GRP_BITS-1:0]     oc_limit;
  logic [2*GRP_BITS-1:0]     ch_prod;
  logic                      grp_bad;
  logic                      range_bad;
  status_t                   status_in;

  assign n_bl_prod = {{ANT_CNT_BITS{1'b0}}, n_ant}
                   * ({{ANT_CNT_BITS{1'b0}}, n_ant} + (2*ANT_CNT_BITS)'(1));
  assign n_bl      = n_bl_prod[2*ANT_CNT_BITS-1:1];

  assign a1_in    = tri_root(req.baseline_index);
  assign tri_prod = (BL_BITS+1)'({(BL_BITS+1-ANT_BITS)'(0), a1_in}
                  * ({(BL_BITS+1-ANT_BITS)'(0), a1_in} + (BL_BITS+1)'(1)));
  assign a2_diff  = req.baseline_index - tri_prod[BL_BITS:1];

  assign oc_limit = ({{GRP_BITS{1'b0}}, {1'b0, req.out_chan}} + (2*GRP_BITS)'(1))
                  * {{GRP_BITS{1'b0}}, avg_group};
  assign ch_prod  = {{GRP_BITS{1'b0}}, {1'b0, req.out_chan}}
                  * {{GRP_BITS{1'b0}}, avg_group};

  assign grp_bad   = (avg_group == '0) || (avg_group > n_chan);
  assign range_bad = ((2*ANT_CNT_BITS-1)'(req.baseline_index) >= n_bl)
                  || ({1'b0, req.pol_first} >= n_pol)
                  || ({1'b0, req.pol_second} >= n_pol)
                  || (oc_limit > {{GRP_BITS{1'b0}}, n_chan});

  always_comb begin
    if (grp_bad) begin
      status_in = STATUS_AVG;
    end else if (range_bad) begin
      status_in = STATUS_RANGE;
    end else begin
      status_in = STATUS_OK;
    end
  end

  // latched request and loop counters
  status_t              status;
  logic [ANT_BITS-1:0]  a1;
  logic [ANT_BITS-1:0]  a2;
  logic [POL_BITS-1:0]  pf;
  logic [POL_BITS-1:0]  ps;
  logic [CHAN_BITS-1:0] ch_cnt;
  logic [STEP_BITS-1:0] step_cnt;
  logic [GRP_BITS-1:0]  grp_cnt;
  logic                 step_last;
  logic                 grp_last;

  assign step_last = ({1'b0, step_cnt} == (n_step - STEP_CNT_BITS'(1)));
  assign grp_last  = (grp_cnt == (avg_group - GRP_BITS'(1)));

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      status   <= status_in;
      a1       <= a1_in;
      a2       <= a2_diff[ANT_BITS-1:0];
      pf       <= req.pol_first;
      ps       <= req.pol_second;
      ch_cnt   <= ch_prod[CHAN_BITS-1:0];
      step_cnt <= '0;
      grp_cnt  <= '0;
    end else if (cmd.read) begin
      if (step_last) begin
        step_cnt <= '0;
        grp_cnt  <= grp_cnt + GRP_BITS'(1);
        ch_cnt   <= ch_cnt + CHAN_BITS'(1);
      end else begin
        step_cnt <= step_cnt + STEP_BITS'(1);
      end
    end
  end

  // sample store, one write port and two registered read ports
  logic [2*SAMPLE_BITS-1:0] store [STORE_DEPTH];
  logic [ADDR_BITS-1:0]     waddr;
  logic [ADDR_BITS-1:0]     addr_a;
  logic [ADDR_BITS-1:0]     addr_b;

  assign waddr  = {req.chan_index, req.ant_index, req.pol_index, req.step_index};
  assign addr_a = {ch_cnt, a1, pf, step_cnt};
  assign addr_b = {ch_cnt, a2, ps, step_cnt};

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      store[waddr] <= {req.sample_re, req.sample_im};
    end
  end

  logic signed [SAMPLE_BITS-1:0] ar, ai, br, bi;

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      {ar, ai} <= store[addr_a];
      {br, bi} <= store[addr_b];
    end
  end

  // products and accumulation
  logic                        rd_valid;
  logic                        prod_valid;
  logic signed [PROD_BITS-1:0] pr_re, pr_im;
  logic signed [ACC_BITS-1:0]  acc_re, acc_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid   <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      rd_valid   <= cmd.read;
      prod_valid <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    pr_re <= ar * br + ai * bi;
    pr_im <= ai * br - ar * bi;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (prod_valid) begin
      acc_re <= acc_re + ACC_BITS'(pr_re);
      acc_im <= acc_im + ACC_BITS'(pr_im);
    end
  end

  // magnitude, scale, saturate
  logic [ACC_BITS-1:0]   mag_re, mag_im;
  logic [SCALE_BITS-1:0] scaled_re, scaled_im;

  always_ff @(posedge clk) begin
    if (cmd.mag) begin
      mag_re <= acc_re[ACC_BITS-1] ? ACC_BITS'(-acc_re) : ACC_BITS'(acc_re);
      mag_im <= acc_im[ACC_BITS-1] ? ACC_BITS'(-acc_im) : ACC_BITS'(acc_im);
    end
    if (cmd.mul) begin
      scaled_re <= {{NORM_BITS{1'b0}}, mag_re} * {{ACC_BITS{1'b0}}, norm_recip};
      scaled_im <= {{NORM_BITS{1'b0}}, mag_im} * {{ACC_BITS{1'b0}}, norm_recip};
    end
  end

  localparam logic [VIS_BITS-1:0] VIS_POS_LIM = {1'b0, {(VIS_BITS-1){1'b1}}};
  localparam logic [VIS_BITS-1:0] VIS_NEG_LIM = {1'b1, {(VIS_BITS-1){1'b0}}};

  logic [VIS_BITS-1:0] q_re, q_im;
  logic [VIS_BITS-1:0] sat_re, sat_im;

  assign q_re = scaled_re[FRAC_BITS +: VIS_BITS];
  assign q_im = scaled_im[FRAC_BITS +: VIS_BITS];

  always_comb begin
    if (acc_re[ACC_BITS-1]) begin
      sat_re = (q_re > VIS_NEG_LIM) ? VIS_NEG_LIM : (-q_re);
    end else begin
      sat_re = (q_re > VIS_POS_LIM) ? VIS_POS_LIM : q_re;
    end
    if (acc_im[ACC_BITS-1]) begin
      sat_im = (q_im > VIS_NEG_LIM) ? VIS_NEG_LIM : (-q_im);
    end else begin
      sat_im = (q_im > VIS_POS_LIM) ? VIS_POS_LIM : q_im;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      if (status != STATUS_OK) begin
        result.vis_re     <= '0;
        result.vis_im     <= '0;
        result.ant_first  <= '0;
        result.ant_second <= '0;
      end else begin
        result.vis_re     <= sat_re;
        result.vis_im     <= sat_im;
        result.ant_first  <= a1;
        result.ant_second <= a2;
      end
      result.status <= status;
    end
  end

  assign stat.err        = (status != STATUS_OK);
  assign stat.zero_steps = (n_step == '0);
  assign stat.last_read  = step_last && grp_last;
  assign stat.pipe_empty = !rd_valid && !prod_valid;

endmodule

`default_nettype wire

>>> dv/bcc_visibility_checker.sv
// ----------------------------------------------------------------------------
// bcc_visibility_checker: predicts and checks baseline visibilities
// follows register writes and sample loads, works out each correlate
// transaction's visibility and compares it with what done marks
// ----------------------------------------------------------------------------
`default_nettype none

module bcc_visibility_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [bcc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [bcc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               start,
  input  logic                               busy,
  input  bcc_pkg::req_t                      req,
  input  logic                               done,
  input  bcc_pkg::result_t                   result,
  output int                                 mismatch_count,
  output int                                 vis_pending
);

  import bcc_pkg::*;

  logic [ANT_CNT_BITS-1:0]  antenna_count;
  logic [POL_CNT_BITS-1:0]  pol_count;
  logic [STEP_CNT_BITS-1:0] step_count;
  logic [CHAN_CNT_BITS-1:0] channel_count;
  logic [GRP_BITS-1:0]      avg_group;
  logic [NORM_BITS-1:0]     norm_recip;

  logic signed [SAMPLE_BITS-1:0] voltage_re [STORE_DEPTH];
  logic signed [SAMPLE_BITS-1:0] voltage_im [STORE_DEPTH];

  result_t expected_vis [$];
  int      errors_seen;

  function automatic int unsigned voltage_addr(int unsigned ch, int unsigned ant,
                                               int unsigned pol, int unsigned step);
    return ((ch * ANT_MAX + ant) * POL_MAX + pol) * STEP_MAX + step;
  endfunction

  // magnitude times Q8.24 scale, fraction dropped, then clamped to 36 bits
  function automatic logic [VIS_BITS-1:0] scale_vis(longint sum);
    logic [63:0] mag;
    logic [63:0] q;
    mag = (sum < 0) ? 64'(-sum) : 64'(sum);
    q = (mag >> FRAC_BITS) * 64'(norm_recip)
      + (((mag & 64'hFF_FFFF) * 64'(norm_recip)) >> FRAC_BITS);
    if (sum < 0) begin
      if (q > (64'd1 << (VIS_BITS - 1))) q = 64'd1 << (VIS_BITS - 1);
      q = -q;
    end else if (q > ((64'd1 << (VIS_BITS - 1)) - 1)) begin
      q = (64'd1 << (VIS_BITS - 1)) - 1;
    end
    return q[VIS_BITS-1:0];
  endfunction

  function automatic result_t predict_visibility(req_t r);
    int unsigned n_ant, n_pol, n_step, n_chan, grp, n_bl, b, a1, a2, ch, s, ia, ib;
    longint acc_re, acc_im, ar, ai, br, bi;
    result_t v;
    n_ant  = (antenna_count > ANT_MAX) ? ANT_MAX : antenna_count;
    n_pol  = (pol_count > POL_MAX) ? POL_MAX : pol_count;
    n_step = (step_count > STEP_MAX) ? STEP_MAX : step_count;
    n_chan = (channel_count > CHAN_MAX) ? CHAN_MAX : channel_count;
    grp    = avg_group;
    b      = r.baseline_index;
    n_bl   = n_ant * (n_ant + 1) / 2;
    a1 = 0;
    while ((a1 + 1) * (a1 + 2) / 2 <= b) a1++;
    a2 = b - a1 * (a1 + 1) / 2;
    v = '0;
    if (grp == 0 || grp > n_chan) begin
      v.status = STATUS_AVG;
    end else if (b >= n_bl || r.pol_first >= n_pol || r.pol_second >= n_pol ||
                 r.out_chan >= n_chan / grp) begin
      v.status = STATUS_RANGE;
    end else begin
      acc_re = 0;
      acc_im = 0;
      for (ch = r.out_chan * grp; ch < r.out_chan * grp + grp; ch++) begin
        for (s = 0; s < n_step; s++) begin
          ia = voltage_addr(ch, a1, r.pol_first, s);
          ib = voltage_addr(ch, a2, r.pol_second, s);
          ar = voltage_re[ia];
          ai = voltage_im[ia];
          br = voltage_re[ib];
          bi = voltage_im[ib];
          acc_re += ar * br + ai * bi;
          acc_im += ai * br - ar * bi;
        end
      end
      v.vis_re     = scale_vis(acc_re);
      v.vis_im     = scale_vis(acc_im);
      v.ant_first  = a1[3:0];
      v.ant_second = a2[3:0];
      v.status     = STATUS_OK;
    end
    return v;
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t %s expected %0d actual %0d", $time, name, want, got);
      errors_seen++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      antenna_count = 5'd16;
      pol_count     = 2'd2;
      step_count    = 7'd64;
      channel_count = 5'd16;
      avg_group     = 5'd1;
      norm_recip    = 32'h0100_0000;
      expected_vis.delete();
      errors_seen = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_ANTENNA_COUNT: antenna_count = cfg_data[ANT_CNT_BITS-1:0];
          REG_POL_COUNT:     pol_count     = cfg_data[POL_CNT_BITS-1:0];
          REG_STEP_COUNT:    step_count    = cfg_data[STEP_CNT_BITS-1:0];
          REG_CHANNEL_COUNT: channel_count = cfg_data[CHAN_CNT_BITS-1:0];
          REG_AVG_GROUP:     avg_group     = cfg_data[GRP_BITS-1:0];
          REG_NORM_RECIP:    norm_recip    = cfg_data[NORM_BITS-1:0];
          default: ;
        endcase
      end
      if (done) begin
        if (expected_vis.size() == 0) begin
          $display("%0t unexpected visibility, status %0d", $time, result.status);
          errors_seen++;
        end else begin
          want = expected_vis.pop_front();
          check_field("vis_re", 64'(want.vis_re), 64'(result.vis_re));
          check_field("vis_im", 64'(want.vis_im), 64'(result.vis_im));
          check_field("ant_first", 64'(want.ant_first), 64'(result.ant_first));
          check_field("ant_second", 64'(want.ant_second), 64'(result.ant_second));
          check_field("status", 64'(want.status), 64'(result.status));
        end
      end
      if (start && !busy) begin
        if (req.func == FUNC_LOAD) begin
          voltage_re[voltage_addr(req.chan_index, req.ant_index, req.pol_index,
                                  req.step_index)] = req.sample_re;
          voltage_im[voltage_addr(req.chan_index, req.ant_index, req.pol_index,
                                  req.step_index)] = req.sample_im;
        end else begin
          expected_vis.push_back(predict_visibility(req));
        end
      end
    end
    mismatch_count <= errors_seen;
    vis_pending    <= expected_vis.size();
  end

endmodule

`default_nettype wire

>>> dv/tb_baseline_cross_correlator_unit.sv
// ----------------------------------------------------------------------------
// tb_baseline_cross_correlator_unit: stimulus and verdict for the correlator
// loads voltage samples and requests visibilities under a series of register
// settings; the checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
`default_nettype none

module tb_baseline_cross_correlator_unit;

  import bcc_pkg::*;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int ITEM_TARGET = 580;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
  logic                      start     = 1'b0;
  req_t                      req       = '0;
  logic                      busy;
  logic                      done;
  result_t                   result;

  int mismatch_count;
  int vis_pending;

  // tracks which store entries hold a sample, so no read hits an empty entry
  bit sample_written [STORE_DEPTH];

  // effective register settings, used only to shape the stimulus
  int unsigned cur_ant, cur_pol, cur_step, cur_chan, cur_grp;

  bit          no_gaps = 1'b0;
  int          items_sent = 0;
  int unsigned cycle_count = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  baseline_cross_correlator_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .result    (result)
  );

  bcc_visibility_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .start          (start),
    .busy           (busy),
    .req            (req),
    .done           (done),
    .result         (result),
    .mismatch_count (mismatch_count),
    .vis_pending    (vis_pending)
  );

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("baseline_cross_correlator_unit: mismatch");
      $finish;
    end
  end

  function automatic int unsigned store_addr(int unsigned ch, int unsigned ant,
                                             int unsigned pol, int unsigned step);
    return ((ch * ANT_MAX + ant) * POL_MAX + pol) * STEP_MAX + step;
  endfunction

  // samples lean toward the extremes now and then
  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 8'h80;
      1: return 8'h7f;
      default: return 8'($urandom);
    endcase
  endfunction

  // every field random so the unused ones toggle too
  function automatic req_t random_req();
    req_t r;
    r = req_t'($bits(req_t)'({$urandom, $urandom}));
    return r;
  endfunction

  // one transaction: optional hold-off, then start held until busy is low
  task automatic send_transaction(input req_t r);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  // stop sending and let every outstanding visibility come back
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (vis_pending != 0 || busy) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_BITS-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // registers only change while the block is idle
  task automatic program_regs(input int unsigned ant, input int unsigned pol,
                              input int unsigned step, input int unsigned chan,
                              input int unsigned grp, input logic [31:0] norm);
    drain_results();
    repeat (8) @(posedge clk);
    write_reg(REG_ANTENNA_COUNT, ant);
    write_reg(REG_POL_COUNT, pol);
    write_reg(REG_STEP_COUNT, step);
    write_reg(REG_CHANNEL_COUNT, chan);
    write_reg(REG_AVG_GROUP, grp);
    write_reg(REG_NORM_RECIP, norm);
    cfg_write <= 1'b0;
    cur_ant  = (ant > ANT_MAX) ? ANT_MAX : ant;
    cur_pol  = (pol > POL_MAX) ? POL_MAX : pol;
    cur_step = (step > STEP_MAX) ? STEP_MAX : step;
    cur_chan = (chan > CHAN_MAX) ? CHAN_MAX : chan;
    cur_grp  = grp;
  endtask

  task automatic load_sample(input int unsigned ch, input int unsigned ant,
                             input int unsigned pol, input int unsigned step,
                             input logic [SAMPLE_BITS-1:0] re,
                             input logic [SAMPLE_BITS-1:0] im);
    req_t r;
    r = random_req();
    r.func       = FUNC_LOAD;
    r.chan_index = 4'(ch);
    r.ant_index  = 4'(ant);
    r.pol_index  = 1'(pol);
    r.step_index = 6'(step);
    r.sample_re  = re;
    r.sample_im  = im;
    sample_written[store_addr(ch, ant, pol, step)] = 1'b1;
    send_transaction(r);
  endtask

  // a valid request first loads whatever samples it would read that are empty
  task automatic request_visibility(input int unsigned b, input int unsigned pf,
                                    input int unsigned ps, input int unsigned oc);
    int unsigned a1, a2, ch, s;
    req_t r;
    a1 = 0;
    while ((a1 + 1) * (a1 + 2) / 2 <= b) a1++;
    a2 = b - a1 * (a1 + 1) / 2;
    if (cur_grp != 0 && cur_grp <= cur_chan && b < cur_ant * (cur_ant + 1) / 2 &&
        pf < cur_pol && ps < cur_pol && oc < cur_chan / cur_grp) begin
      for (ch = oc * cur_grp; ch < oc * cur_grp + cur_grp; ch++) begin
        for (s = 0; s < cur_step; s++) begin
          if (!sample_written[store_addr(ch, a1, pf, s)])
            load_sample(ch, a1, pf, s, rand_sample(), rand_sample());
          if (!sample_written[store_addr(ch, a2, ps, s)])
            load_sample(ch, a2, ps, s, rand_sample(), rand_sample());
        end
      end
    end
    r = random_req();
    r.func           = FUNC_CORRELATE;
    r.baseline_index = BL_BITS'(b);
    r.pol_first      = 1'(pf);
    r.pol_second     = 1'(ps);
    r.out_chan       = 4'(oc);
    send_transaction(r);
  endtask

  // mostly well-formed requests, plus stray loads, drains and out of range requests
  task automatic random_action();
    int unsigned pick, n_bl, n_out;
    n_bl  = cur_ant * (cur_ant + 1) / 2;
    n_out = (cur_grp == 0) ? 0 : cur_chan / cur_grp;
    pick  = $urandom_range(0, 99);
    if (pick < 3) begin
      drain_results();
    end else if (pick < 18) begin
      load_sample($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 1),
                  $urandom_range(0, 63), rand_sample(), rand_sample());
    end else if (pick < 30 || n_bl == 0 || cur_pol == 0 || n_out == 0) begin
      request_visibility($urandom_range(0, 255), $urandom_range(0, 1),
                         $urandom_range(0, 1), $urandom_range(0, 15));
    end else begin
      request_visibility($urandom_range(0, n_bl - 1), $urandom_range(0, cur_pol - 1),
                         $urandom_range(0, cur_pol - 1), $urandom_range(0, n_out - 1));
    end
  endtask

  task automatic run_phase(input int unsigned ant, input int unsigned pol,
                           input int unsigned step, input int unsigned chan,
                           input int unsigned grp, input logic [31:0] norm,
                           input int unsigned actions);
    program_regs(ant, pol, step, chan, grp, norm);
    no_gaps = ($urandom_range(0, 3) == 0);
    repeat (actions) random_action();
  endtask

  initial begin
    int unsigned ant, pol, step, chan, grp;
    logic [31:0] norm;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes with one step per visibility and unity scale
    program_regs(16, 2, 1, 16, 1, 32'h0100_0000);
    load_sample(0, 0, 0, 0, 8'h80, 8'h80);
    request_visibility(0, 0, 0, 0);           // autocorrelation, most negative sample
    load_sample(15, 15, 1, 0, 8'h7f, 8'h80);
    load_sample(15, 0, 0, 0, 8'hff, 8'h7f);
    request_visibility(135, 1, 1, 15);        // last baseline of the triangle
    request_visibility(120, 1, 0, 15);        // highest antenna against antenna 0
    request_visibility(120, 0, 1, 15);
    load_sample(15, 15, 1, 63, 8'h00, 8'h01); // highest store address
    load_sample(0, 15, 0, 0, 8'h7f, 8'h7f);
    request_visibility(15, 0, 0, 0);
    request_visibility(136, 0, 0, 0);         // first baseline past the triangle
    request_visibility(255, 1, 1, 15);        // baseline field at its top

    // special settings
    run_phase(4, 2, 3, 16, 1, $urandom, 10);
    run_phase(31, 3, 2, 31, 5, 32'h0000_8000, 8);   // counts above max, leftover channel
    run_phase(16, 2, 0, 16, 2, 32'hffff_ffff, 10);  // empty sum, largest scale
    run_phase(2, 1, 127, 1, 1, 32'h0100_0000, 4);   // step count saturates
    run_phase(2, 1, 4, 16, 16, 32'h0000_0000, 6);   // one full-width group, zero scale
    run_phase(5, 1, 2, 16, 1, $urandom, 10);        // second polarization out of range
    run_phase(0, 2, 2, 16, 1, $urandom, 8);         // no antennas in use
    run_phase(16, 0, 2, 16, 1, $urandom, 8);        // no polarizations in use
    run_phase(16, 2, 2, 0, 1, $urandom, 8);         // no channels, bad averaging
    run_phase(16, 2, 2, 16, 0, $urandom, 8);        // zero averaging group
    run_phase(16, 2, 2, 4, 5, $urandom, 8);         // group wider than channel count
    run_phase(3, 2, 1, 15, 2, $urandom, 16);        // odd channel left over

    // random settings until the item budget is spent
    while (items_sent < ITEM_TARGET) begin
      ant  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 6);
      pol  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 2);
      step = $urandom_range(0, 5);
      chan = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
      grp  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 3);
      case ($urandom_range(0, 3))
        0: norm = $urandom;
        1: norm = 32'h0100_0000;
        2: norm = $urandom_range(0, 32'h00ff_ffff);
        default: norm = 32'hffff_ffff;
      endcase
      run_phase(ant, pol, step, chan, grp, norm, 20);
    end

    // wait out the last visibilities, then a little longer for strays
    drain_results();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && vis_pending == 0) begin
      $display("baseline_cross_correlator_unit: match");
    end else begin
      $display("baseline_cross_correlator_unit: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
src/bcc_pkg.sv
src/bcc_ctrl.sv
src/bcc_datapath.sv
src/baseline_cross_correlator_unit.sv
dv/bcc_visibility_checker.sv
dv/tb_baseline_cross_correlator_unit.sv
